// File: src/twh_pkg.sv
// ----------------------------------------------------------------------------
// twh_pkg: shared definitions for the topmost window hit test
// Field widths and offsets of the stream items, command codes, controller
// states and the control group passed to the evaluation stage.
// ----------------------------------------------------------------------------
package twh_pkg;

	// Field widths of the stream items.
	localparam int IDX_W      = 8;
	localparam int IN_COORD_W = 12;
	localparam int PRIO_W     = 16;
	localparam int SKIP_W     = 9;
	localparam int OUT_W      = 8;

	// Input tdata layout, lowest bit first.
	localparam int OFS_INDEX  = 0;
	localparam int OFS_POS_X  = OFS_INDEX + IDX_W;
	localparam int OFS_POS_Y  = OFS_POS_X + IN_COORD_W;
	localparam int OFS_WIDTH  = OFS_POS_Y + IN_COORD_W;
	localparam int OFS_HEIGHT = OFS_WIDTH + IN_COORD_W;
	localparam int OFS_PRIO   = OFS_HEIGHT + IN_COORD_W;
	localparam int S_TDATA_W  = OFS_PRIO + PRIO_W;

	// Reset value of the skipped index: names no entry.
	localparam logic [SKIP_W-1:0] SKIP_NONE = 9'd256;

	// Command carried in tuser.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Control towards the evaluation stage.
	typedef struct packed {
		logic clear;   // start of a query: reset best priority and winner
		logic valid;   // table read data is present this cycle
	} eval_ctl_t;

endpackage

// File: src/twh_ram.sv
// ----------------------------------------------------------------------------
// twh_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module twh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/twh_eval.sv
// ----------------------------------------------------------------------------
// twh_eval: per-entry coverage test and running winner
// Tests one table entry a cycle against the query point and keeps the best
// priority and the index that holds it.
// ----------------------------------------------------------------------------
module twh_eval #(
	parameter int CW = 12,
	parameter int AW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  twh_pkg::eval_ctl_t         ctl,
	input  logic [AW-1:0]              idx_s1,
	input  logic [4*CW+twh_pkg::PRIO_W-1:0] entry,
	input  logic [CW-1:0]              point_x,
	input  logic [CW-1:0]              point_y,
	input  logic [twh_pkg::SKIP_W-1:0] skipped,
	output logic [AW-1:0]              found
);

	logic        [CW-1:0]               left, top, wid, hgt;
	logic signed [twh_pkg::PRIO_W-1:0]  prio;
	logic        [CW:0]                 right_edge, bottom_edge;
	logic                               covers, skip, hit;
	logic signed [twh_pkg::PRIO_W-1:0]  best_q;
	logic        [AW-1:0]               found_q;

	assign left   = entry[0*CW +: CW];
	assign top    = entry[1*CW +: CW];
	assign wid    = entry[2*CW +: CW];
	assign hgt    = entry[3*CW +: CW];
	assign prio   = signed'(entry[4*CW +: twh_pkg::PRIO_W]);

	// Edges are formed one bit wider so that they cannot wrap.
	assign right_edge  = {1'b0, left} + {1'b0, wid};
	assign bottom_edge = {1'b0, top} + {1'b0, hgt};

	assign covers = (left <= point_x) && (top <= point_y) &&
	                (right_edge > {1'b0, point_x}) && (bottom_edge > {1'b0, point_y});
	assign skip   = (32'(idx_s1) == 32'(skipped));
	// The best priority starts at zero, so a window with a negative priority never wins.
	assign hit    = ctl.valid && !skip && covers && (prio >= best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			found_q <= '0;
		end else if (ctl.clear) begin
			best_q  <= '0;
			found_q <= '0;
		end else if (hit) begin
			best_q  <= prio;
			found_q <= idx_s1;
		end
	end

	assign found = found_q;

endmodule

// File: src/topmost_window_hit_test.sv
// ----------------------------------------------------------------------------
// topmost_window_hit_test: topmost window under a point
// Holds a table of window rectangles with stacking priorities in one RAM and
// answers point queries by scanning it, one entry per cycle.
//
// Input stream (s_*): tuser is the command. A write item stores one entry and
// gives no result. A query item gives one result item on the output stream
// (m_*): the index of the topmost covering window, or 0. A query reads
// entries 0 up to the highest written index, one RAM read a cycle, through
// the states SCAN, DRAIN and FINISH; the result is then presented in the
// output register, and the next item is taken once the block is back in IDLE.
// Configuration (cfg_*): the skipped pointer index, taken in any cycle.
// After reset the block sweeps the whole table to zero and holds s_tready low
// meanwhile. A result that the receiver stalls waits in the output register;
// the block still accepts items, and a further query holds its answer until
// the output register is free.
// ----------------------------------------------------------------------------
module topmost_window_hit_test #(
	parameter int TABLE_ENTRIES = 256,
	parameter int COORD_BITS    = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tdata: entry_index[7:0], pos_x[19:8], pos_y[31:20], rect_width[43:32],
	//        rect_height[55:44], priority_req[71:56]
	input  logic [twh_pkg::S_TDATA_W-1:0] s_tdata,
	// tuser: command (0 write entry, 1 query point)
	input  logic                          s_tuser,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata: window_index[7:0]
	output logic [twh_pkg::OUT_W-1:0]     m_tdata,
	// Configuration: skipped_index
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twh_pkg::SKIP_W-1:0]    cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = COORD_BITS;
	localparam int EW = 4 * CW + twh_pkg::PRIO_W;

	// Input fields.
	logic [twh_pkg::IDX_W-1:0]      in_index;
	logic [twh_pkg::IN_COORD_W-1:0] in_x, in_y, in_w, in_h;
	logic [twh_pkg::PRIO_W-1:0]     in_prio;
	logic                           in_range;

	twh_pkg::state_t state_q, state_d;

	logic [AW-1:0]               rd_addr_q;
	logic [AW-1:0]               highest_q;
	logic [twh_pkg::SKIP_W-1:0]  skipped_q;
	logic [CW-1:0]               point_x_q, point_y_q;
	logic                        valid_s1;
	logic [AW-1:0]               idx_s1;
	logic                        out_valid_q;
	logic [twh_pkg::OUT_W-1:0]   out_data_q;

	// Controller outputs.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic                 rd_en;
	logic                 load_out;
	logic                 query_start;
	logic                 write_take;
	logic [EW-1:0]        ram_rdata;
	logic [AW-1:0]        found;
	twh_pkg::eval_ctl_t   eval_ctl;

	assign in_index = s_tdata[twh_pkg::OFS_INDEX  +: twh_pkg::IDX_W];
	assign in_x     = s_tdata[twh_pkg::OFS_POS_X  +: twh_pkg::IN_COORD_W];
	assign in_y     = s_tdata[twh_pkg::OFS_POS_Y  +: twh_pkg::IN_COORD_W];
	assign in_w     = s_tdata[twh_pkg::OFS_WIDTH  +: twh_pkg::IN_COORD_W];
	assign in_h     = s_tdata[twh_pkg::OFS_HEIGHT +: twh_pkg::IN_COORD_W];
	assign in_prio  = s_tdata[twh_pkg::OFS_PRIO   +: twh_pkg::PRIO_W];

	// A write to an index beyond the table is dropped.
	assign in_range = (32'(in_index) < TABLE_ENTRIES);

	assign cfg_ready = 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			twh_pkg::ST_CLEAR: begin
				if (rd_addr_q == AW'(TABLE_ENTRIES - 1)) state_d = twh_pkg::ST_IDLE;
			end
			twh_pkg::ST_IDLE: begin
				if (s_tvalid && s_tuser == twh_pkg::CMD_QUERY) state_d = twh_pkg::ST_SCAN;
			end
			twh_pkg::ST_SCAN: begin
				if (rd_addr_q == highest_q) state_d = twh_pkg::ST_DRAIN;
			end
			twh_pkg::ST_DRAIN: begin
				state_d = twh_pkg::ST_FINISH;
			end
			twh_pkg::ST_FINISH: begin
				if (!out_valid_q || m_tready) state_d = twh_pkg::ST_IDLE;
			end
			default: begin
				state_d = twh_pkg::ST_IDLE;
			end
		endcase
	end

	// Controller outputs.
	always_comb begin
		s_tready    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = rd_addr_q;
		ram_wdata   = '0;
		rd_en       = 1'b0;
		load_out    = 1'b0;
		query_start = 1'b0;
		write_take  = 1'b0;
		unique case (state_q)
			twh_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			twh_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == twh_pkg::CMD_QUERY) begin
					query_start = 1'b1;
				end
				if (s_tvalid && s_tuser == twh_pkg::CMD_WRITE && in_range) begin
					write_take = 1'b1;
					ram_we     = 1'b1;
					ram_waddr  = AW'(in_index);
					ram_wdata  = {in_prio, CW'(in_h), CW'(in_w), CW'(in_y), CW'(in_x)};
				end
			end
			twh_pkg::ST_SCAN: begin
				rd_en = 1'b1;
			end
			twh_pkg::ST_DRAIN: begin
			end
			twh_pkg::ST_FINISH: begin
				load_out = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= twh_pkg::ST_CLEAR;
			rd_addr_q   <= '0;
			highest_q   <= '0;
			skipped_q   <= twh_pkg::SKIP_NONE;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;

			if (cfg_valid) begin
				skipped_q <= cfg_data;
			end

			// The same counter walks the table for the clearing pass and the scan.
			unique case (state_q)
				twh_pkg::ST_CLEAR: begin
					if (rd_addr_q == AW'(TABLE_ENTRIES - 1)) rd_addr_q <= '0;
					else rd_addr_q <= rd_addr_q + 1'b1;
				end
				twh_pkg::ST_SCAN: begin
					if (rd_addr_q != highest_q) rd_addr_q <= rd_addr_q + 1'b1;
				end
				default: begin
					rd_addr_q <= '0;
				end
			endcase

			if (write_take && AW'(in_index) > highest_q) begin
				highest_q <= AW'(in_index);
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		if (query_start) begin
			point_x_q <= CW'(in_x);
			point_y_q <= CW'(in_y);
		end
		if (load_out) begin
			out_data_q <= twh_pkg::OUT_W'(found);
		end
	end

	twh_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	assign eval_ctl.clear = query_start;
	assign eval_ctl.valid = valid_s1;

	twh_eval #(
		.CW (CW),
		.AW (AW)
	) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (eval_ctl),
		.idx_s1  (idx_s1),
		.entry   (ram_rdata),
		.point_x (point_x_q),
		.point_y (point_y_q),
		.skipped (skipped_q),
		.found   (found)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// The scan address never runs past the highest written entry.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twh_pkg::ST_SCAN) |-> (rd_addr_q <= highest_q))
		else $error("scan address beyond highest written entry");

	// Read data is evaluated only while a query is scanning or draining.
	a_eval_window: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == twh_pkg::ST_SCAN || state_q == twh_pkg::ST_DRAIN))
		else $error("table data evaluated outside a query");

	// The winner always lies within the scanned range.
	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twh_pkg::ST_FINISH) |-> (found <= highest_q))
		else $error("winning index beyond scanned range");

	// A finished query presents its result in the next cycle.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twh_pkg::ST_FINISH && (!out_valid_q || m_tready)) |=> out_valid_q)
		else $error("finished query did not present a result");
`endif

endmodule
